### src/tsr_pkg.sv
package tsr_pkg;

  localparam int RECORDS = 16;
  localparam int IDX_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W   = $clog2(RECORDS + 1);

  localparam logic [7:0] TRACKER_MIN_ID = 8'd3;
  localparam logic [7:0] BASE2_ID       = 8'd2;

  localparam logic [1:0] CMD_RX  = 2'd0;
  localparam logic [1:0] CMD_TMO = 2'd1;
  localparam logic [1:0] CMD_TXD = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_LISTEN = 2'd1;
  localparam logic [1:0] ACT_SEND   = 2'd2;

  localparam logic [1:0] KIND_TRACKER = 2'd0;
  localparam logic [1:0] KIND_SEQ     = 2'd1;
  localparam logic [1:0] KIND_BASE    = 2'd2;

  localparam logic [0:0] REG_LAST_ID   = 1'b0;
  localparam logic [0:0] REG_MAX_WRONG = 1'b1;

  localparam logic [7:0] LAST_ID_RST   = 8'd15;
  localparam logic [7:0] MAX_WRONG_RST = 8'd3;

  typedef enum logic [2:0] {
    PH_WAIT_TRK = 3'd0,
    PH_RECV_TRK = 3'd1,
    PH_TX       = 3'd2,
    PH_WAIT_B2  = 3'd3,
    PH_RECV_B2  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [7:0]          sender_id;
    logic [7:0]          frame_index;
    logic signed [15:0]  rx_rssi;
    logic signed [7:0]   rx_snr;
    logic [31:0]         now_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [1:0]          listen_kind;
    logic [7:0]          send_index;
    logic [31:0]         send_time;
    logic signed [15:0]  send_rssi;
    logic signed [7:0]   send_snr;
    logic [2:0]          phase;
  } out_item_t;

  typedef struct packed {
    logic [31:0]         ts;
    logic signed [15:0]  rssi;
    logic signed [7:0]   snr;
  } rec_t;

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    rec_t             wr_data;
  } store_req_t;

endpackage

### src/tsr_if.sv
interface tsr_in_if;
  import tsr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tsr_out_if;
  import tsr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/timestamp_relay_base_sequencer.sv
// channel  dir  fields                                                            handshake
// in_i     in   cmd sender_id frame_index rx_rssi rx_snr now_ns                   valid/ready
// out_o    out  action listen_kind send_index send_time send_rssi send_snr phase  valid/ready
// apb      in   last_message_id at 0x0, max_wrong_count at 0x4                    psel/penable
//
// one event per cycle sustained while the receiver takes results; an input transfer reaches the result
// through the input register, then the phase logic and store read into the result register
// 16 flip-flop store entries with a valid bit each, so a tracker start clears it in the
// same cycle and no clearing pass follows reset
// asynchronous active-low reset restores phase, counters, valid bits and both registers
// a stalled result holds the result register; the input stalls only once both are full
module timestamp_relay_base_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsr_in_if.sink      in_i,
  tsr_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsr_pkg::*;

  // configuration registers
  logic [7:0] last_id_q;
  logic [7:0] max_wrong_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q   <= LAST_ID_RST;
      max_wrong_q <= MAX_WRONG_RST;
    end else if (cfg_wr) begin
      case (paddr[2:2])
        REG_LAST_ID:   last_id_q   <= pwdata[7:0];
        REG_MAX_WRONG: max_wrong_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      REG_LAST_ID:   prdata = {24'd0, last_id_q};
      REG_MAX_WRONG: prdata = {24'd0, max_wrong_q};
      default:       prdata = '0;
    endcase
  end

  // input register
  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     advance;
  logic     fire;
  logic     in_xfer;

  // result register
  logic      out_valid_q;
  out_item_t out_item_q;

  // the result register frees up when empty or taken this cycle
  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = s1_valid_q && advance;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_xfer     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_i.payload;
    end
  end

  // phase logic and record store
  store_req_t       store_req;
  rec_t             rd_data;
  out_item_t        res;
  logic [CNT_W-1:0] send_cnt;

  tsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (s1_item_q),
    .last_id_i   (last_id_q),
    .max_wrong_i (max_wrong_q),
    .rd_data_i   (rd_data),
    .req_o       (store_req),
    .res_o       (res),
    .send_cnt_o  (send_cnt)
  );

  tsr_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // send counter never runs past the end of the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_cnt <= CNT_W'(RECORDS))
    else $error("send counter beyond store size");

  // an event never lands in a full input register that is not draining
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s1_valid_q) |-> fire)
    else $error("input register overrun");

  // a record transfer always leaves the block in the transmitting phase
  a_send_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.action == ACT_SEND)) |->
      (out_item_q.phase == 3'(PH_TX)) && (out_item_q.listen_kind == KIND_TRACKER))
    else $error("record sent outside transmit phase");

  // every processed event produces exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed event produced no result");

endmodule

### src/tsr_store.sv
module tsr_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsr_pkg::store_req_t req_i,
  output tsr_pkg::rec_t       rd_data_o
);
  import tsr_pkg::*;

  rec_t               data_q [RECORDS];
  logic [RECORDS-1:0] valid_q;
  logic [RECORDS-1:0] valid_d;

  // a clear drops every entry back to all ones, a write in the same cycle survives it
  always_comb begin
    valid_d = req_i.clear ? '0 : valid_q;
    if (req_i.wr_en) begin
      valid_d[req_i.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      data_q[req_i.wr_idx] <= req_i.wr_data;
    end
  end

  // read sees the write and clear of the same cycle
  always_comb begin
    if (req_i.wr_en && (req_i.wr_idx == req_i.rd_idx)) begin
      rd_data_o = req_i.wr_data;
    end else if (req_i.clear || !valid_q[req_i.rd_idx]) begin
      rd_data_o = '1;
    end else begin
      rd_data_o = data_q[req_i.rd_idx];
    end
  end

endmodule

### src/tsr_ctrl.sv
module tsr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tsr_pkg::in_item_t   item_i,
  input  logic [7:0]          last_id_i,
  input  logic [7:0]          max_wrong_i,
  input  tsr_pkg::rec_t       rd_data_i,
  output tsr_pkg::store_req_t req_o,
  output tsr_pkg::out_item_t  res_o,
  output logic [tsr_pkg::CNT_W-1:0] send_cnt_o
);
  import tsr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] send_cnt_q, send_cnt_d;
  logic [7:0]       wrong_cnt_q, wrong_cnt_d;
  logic [7:0]       wrong_inc;

  logic             rx, tmo, txd, tracker, base2, track;
  logic             send_en, write_en, clear_en;
  logic [IDX_W-1:0] send_idx;
  logic [1:0]       listen_kind;
  logic             listen_en;

  assign rx        = (item_i.cmd == CMD_RX);
  assign tmo       = (item_i.cmd == CMD_TMO);
  assign txd       = (item_i.cmd == CMD_TXD);
  assign tracker   = (item_i.sender_id >= TRACKER_MIN_ID);
  assign base2     = (item_i.sender_id == BASE2_ID);
  assign wrong_inc = wrong_cnt_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    send_cnt_d  = send_cnt_q;
    wrong_cnt_d = wrong_cnt_q;
    track       = 1'b0;
    send_en     = 1'b0;
    send_idx    = '0;
    listen_en   = 1'b0;
    listen_kind = KIND_TRACKER;
    write_en    = 1'b0;
    clear_en    = 1'b0;

    case (phase_q)
      PH_WAIT_TRK: begin
        if (rx && tracker) begin
          clear_en = 1'b1;
          phase_d  = PH_RECV_TRK;
          track    = 1'b1;
        end else if (rx || tmo) begin
          listen_en   = 1'b1;
          listen_kind = KIND_TRACKER;
        end
      end
      PH_RECV_TRK: begin
        if (rx && tracker) begin
          track = 1'b1;
        end else if (rx) begin
          listen_en   = 1'b1;
          listen_kind = KIND_SEQ;
        end else if (tmo) begin
          send_en    = 1'b1;
          send_cnt_d = CNT_W'(1);
          phase_d    = PH_TX;
        end
      end
      PH_TX: begin
        if (txd) begin
          if (send_cnt_q < CNT_W'(RECORDS)) begin
            send_en    = 1'b1;
            send_idx   = send_cnt_q[IDX_W-1:0];
            send_cnt_d = send_cnt_q + CNT_W'(1);
          end else begin
            listen_en   = 1'b1;
            listen_kind = KIND_BASE;
            phase_d     = PH_WAIT_B2;
          end
        end
      end
      PH_WAIT_B2: begin
        if (rx && base2) begin
          phase_d     = PH_RECV_B2;
          listen_en   = 1'b1;
          listen_kind = KIND_SEQ;
        end else if (rx) begin
          listen_en = 1'b1;
          if (wrong_inc == max_wrong_i) begin
            phase_d     = PH_WAIT_TRK;
            wrong_cnt_d = '0;
            listen_kind = KIND_TRACKER;
          end else begin
            wrong_cnt_d = wrong_inc;
            listen_kind = KIND_BASE;
          end
        end else if (tmo) begin
          listen_en   = 1'b1;
          listen_kind = KIND_TRACKER;
          phase_d     = PH_WAIT_TRK;
        end
      end
      PH_RECV_B2: begin
        if (rx) begin
          listen_en = 1'b1;
          if (base2 && (item_i.frame_index == last_id_i)) begin
            listen_kind = KIND_TRACKER;
            phase_d     = PH_WAIT_TRK;
          end else begin
            listen_kind = KIND_SEQ;
          end
        end else if (tmo) begin
          listen_en   = 1'b1;
          listen_kind = KIND_TRACKER;
          phase_d     = PH_WAIT_TRK;
        end
      end
      default: begin
      end
    endcase

    // tracker frame: record it, then either close the sequence or keep listening
    if (track) begin
      write_en = ({1'b0, item_i.frame_index} < 9'(RECORDS));
      if (item_i.frame_index == last_id_i) begin
        send_en    = 1'b1;
        send_idx   = '0;
        send_cnt_d = CNT_W'(1);
        phase_d    = PH_TX;
      end else begin
        listen_en   = 1'b1;
        listen_kind = KIND_SEQ;
      end
    end
  end

  always_comb begin
    req_o.clear        = fire_i && clear_en;
    req_o.wr_en        = fire_i && write_en;
    req_o.wr_idx       = item_i.frame_index[IDX_W-1:0];
    req_o.rd_idx       = send_idx;
    req_o.wr_data.ts   = item_i.now_ns;
    req_o.wr_data.rssi = item_i.rx_rssi;
    req_o.wr_data.snr  = item_i.rx_snr;
  end

  always_comb begin
    res_o       = '0;
    res_o.phase = phase_d;
    if (send_en) begin
      res_o.action     = ACT_SEND;
      res_o.send_index = 8'(send_idx);
      res_o.send_time  = rd_data_i.ts;
      res_o.send_rssi  = rd_data_i.rssi;
      res_o.send_snr   = rd_data_i.snr;
    end else if (listen_en) begin
      res_o.action      = ACT_LISTEN;
      res_o.listen_kind = listen_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_TRK;
      send_cnt_q  <= '0;
      wrong_cnt_q <= '0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      send_cnt_q  <= send_cnt_d;
      wrong_cnt_q <= wrong_cnt_d;
    end
  end

  assign send_cnt_o = send_cnt_q;

endmodule

### sim/tb_timestamp_relay_base_sequencer.sv
module tb_timestamp_relay_base_sequencer;
  import tsr_pkg::*;

  // event code that the block must ignore in every phase
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // register map: one 32-bit word per register
  localparam logic [2:0] ADDR_LAST_ID   = {REG_LAST_ID, 2'b00};
  localparam logic [2:0] ADDR_MAX_WRONG = {REG_MAX_WRONG, 2'b00};

  // watchdog limit for a run of roughly 750 events
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned MAX_GAP      = 20;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tsr_in_if  events_ch ();
  tsr_out_if orders_ch ();

  timestamp_relay_base_sequencer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (events_ch),
    .out_o   (orders_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // sequencer model: its own copy of phase, record store, counters and registers
  // --------------------------------------------------------------------------
  phase_e      model_phase;
  rec_t        model_store [RECORDS];
  int unsigned model_sent;
  logic [7:0]  model_wrong;
  logic [7:0]  model_last_id;
  logic [7:0]  model_max_wrong;

  // listen orders and record sends still owed by the block, oldest first
  out_item_t   pending_orders [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // one line of the directed table; want is only used where typed is set
  typedef struct {
    in_item_t    ev;
    int unsigned reps;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic out_item_t listen_order(logic [1:0] kind);
    out_item_t r;
    r             = '0;
    r.action      = ACT_LISTEN;
    r.listen_kind = kind;
    return r;
  endfunction

  function automatic out_item_t send_record(int unsigned idx);
    out_item_t r;
    r            = '0;
    r.action     = ACT_SEND;
    r.send_index = 8'(idx);
    r.send_time  = model_store[idx].ts;
    r.send_rssi  = model_store[idx].rssi;
    r.send_snr   = model_store[idx].snr;
    return r;
  endfunction

  // advances the model by one radio event and returns the order it gives
  function automatic out_item_t relay_step(in_item_t ev);
    out_item_t r;
    logic      rx;
    logic      tmo;
    logic      txd;
    logic      track;
    r     = '0;
    rx    = (ev.cmd == CMD_RX);
    tmo   = (ev.cmd == CMD_TMO);
    txd   = (ev.cmd == CMD_TXD);
    track = 1'b0;

    case (model_phase)
      PH_WAIT_TRK: begin
        // a tracker frame wipes the store and is then recorded like any other
        if (rx && ev.sender_id >= TRACKER_MIN_ID) begin
          foreach (model_store[i]) model_store[i] = '1;
          model_phase = PH_RECV_TRK;
          track       = 1'b1;
        end else if (rx || tmo) begin
          r = listen_order(KIND_TRACKER);
        end
      end
      PH_RECV_TRK: begin
        if (rx && ev.sender_id >= TRACKER_MIN_ID) begin
          track = 1'b1;
        end else if (rx) begin
          r = listen_order(KIND_SEQ);
        end else if (tmo) begin
          r           = send_record(0);
          model_sent  = 1;
          model_phase = PH_TX;
        end
      end
      PH_TX: begin
        if (txd) begin
          if (model_sent < RECORDS) begin
            r = send_record(model_sent);
            model_sent++;
          end else begin
            r           = listen_order(KIND_BASE);
            model_phase = PH_WAIT_B2;
          end
        end
      end
      PH_WAIT_B2: begin
        if (rx && ev.sender_id == BASE2_ID) begin
          model_phase = PH_RECV_B2;
          r           = listen_order(KIND_SEQ);
        end else if (rx) begin
          // 8-bit count that wraps; cleared only on a match
          model_wrong = model_wrong + 8'd1;
          if (model_wrong == model_max_wrong) begin
            model_phase = PH_WAIT_TRK;
            model_wrong = '0;
            r           = listen_order(KIND_TRACKER);
          end else begin
            r = listen_order(KIND_BASE);
          end
        end else if (tmo) begin
          r           = listen_order(KIND_TRACKER);
          model_phase = PH_WAIT_TRK;
        end
      end
      PH_RECV_B2: begin
        if (rx) begin
          if (ev.sender_id == BASE2_ID && ev.frame_index == model_last_id) begin
            r           = listen_order(KIND_TRACKER);
            model_phase = PH_WAIT_TRK;
          end else begin
            r = listen_order(KIND_SEQ);
          end
        end else if (tmo) begin
          r           = listen_order(KIND_TRACKER);
          model_phase = PH_WAIT_TRK;
        end
      end
      default: ;
    endcase

    if (track) begin
      // ids past the store are not recorded but may still close the sequence
      if (ev.frame_index < RECORDS) begin
        model_store[ev.frame_index].ts   = ev.now_ns;
        model_store[ev.frame_index].rssi = ev.rx_rssi;
        model_store[ev.frame_index].snr  = ev.rx_snr;
      end
      if (ev.frame_index == model_last_id) begin
        r           = send_record(0);
        model_sent  = 1;
        model_phase = PH_TX;
      end else begin
        r = listen_order(KIND_SEQ);
      end
    end

    r.phase = model_phase;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus generation
  // --------------------------------------------------------------------------
  function automatic in_item_t radio_event(logic [1:0] cmd, logic [7:0] sid,
                                           logic [7:0] fidx, logic signed [15:0] rssi,
                                           logic signed [7:0] snr, logic [31:0] now);
    in_item_t ev;
    ev.cmd         = cmd;
    ev.sender_id   = sid;
    ev.frame_index = fidx;
    ev.rx_rssi     = rssi;
    ev.rx_snr      = snr;
    ev.now_ns      = now;
    return ev;
  endfunction

  function automatic out_item_t relay_result(logic [1:0] act, logic [1:0] kind,
                                             logic [7:0] idx, logic [31:0] t,
                                             logic signed [15:0] rssi,
                                             logic signed [7:0] snr, phase_e ph);
    out_item_t r;
    r.action      = act;
    r.listen_kind = kind;
    r.send_index  = idx;
    r.send_time   = t;
    r.send_rssi   = rssi;
    r.send_snr    = snr;
    r.phase       = ph;
    return r;
  endfunction

  task automatic add_row(in_item_t ev, int unsigned reps, bit typed, out_item_t want);
    stim_row_t row;
    row.ev    = ev;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // mostly the event that the model's current phase is waiting for, with
  // random content; the rest is noise of any code and any field value
  function automatic in_item_t next_event();
    in_item_t    ev;
    int unsigned pick;
    ev.cmd         = CMD_RX;
    ev.sender_id   = 8'($urandom);
    ev.frame_index = 8'($urandom);
    ev.rx_rssi     = 16'($urandom);
    ev.rx_snr      = 8'($urandom);
    ev.now_ns      = $urandom;
    pick           = $urandom_range(99);
    if (pick < 12) begin
      ev.cmd = 2'($urandom);
      return ev;
    end
    case (model_phase)
      PH_WAIT_TRK: begin
        if (pick < 85) ev.sender_id = 8'($urandom_range(255, TRACKER_MIN_ID));
        else if (pick < 93) ev.cmd = CMD_TMO;
      end
      PH_RECV_TRK: begin
        ev.sender_id = 8'($urandom_range(255, TRACKER_MIN_ID));
        if (pick < 30) ev.frame_index = model_last_id;
        else if (pick < 42) ev.cmd = CMD_TMO;
        else if (pick < 52) ev.sender_id = 8'($urandom_range(TRACKER_MIN_ID - 1));
        else if (pick < 90) ev.frame_index = 8'($urandom_range(RECORDS - 1));
      end
      PH_TX: begin
        ev.cmd = CMD_TXD;
      end
      PH_WAIT_B2: begin
        if (pick < 45) ev.sender_id = BASE2_ID;
        else if (pick < 88) begin
          if (ev.sender_id == BASE2_ID) ev.sender_id = TRACKER_MIN_ID;
        end else ev.cmd = CMD_TMO;
      end
      PH_RECV_B2: begin
        if (pick < 40) begin
          ev.sender_id   = BASE2_ID;
          ev.frame_index = model_last_id;
        end else if (pick < 60) ev.sender_id = BASE2_ID;
        else if (pick >= 88) ev.cmd = CMD_TMO;
      end
      default: ;
    endcase
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic compare_field(string field_name, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (got !== want)
      note_failure($sformatf("%s: expected %0d, got %0d", field_name, want, got));
  endtask

  task automatic check_order(out_item_t got);
    out_item_t want;
    if (pending_orders.size() == 0) begin
      note_failure($sformatf("order %h with no event outstanding", got));
    end else begin
      want = pending_orders.pop_front();
      compare_field("action",      want.action,      got.action);
      compare_field("listen_kind", want.listen_kind, got.listen_kind);
      compare_field("send_index",  want.send_index,  got.send_index);
      compare_field("send_time",   want.send_time,   got.send_time);
      compare_field("send_rssi",   want.send_rssi,   got.send_rssi);
      compare_field("send_snr",    want.send_snr,    got.send_snr);
      compare_field("phase",       want.phase,       got.phase);
    end
  endtask

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  // setup then access; ends at a falling edge with psel dropped
  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_LAST_ID, '0, rd);
    if (rd !== {24'd0, model_last_id})
      note_failure($sformatf("last_message_id reads %h, expected %h", rd, model_last_id));
    apb_access(1'b0, ADDR_MAX_WRONG, '0, rd);
    if (rd !== {24'd0, model_max_wrong})
      note_failure($sformatf("max_wrong_count reads %h, expected %h", rd, model_max_wrong));
  endtask

  task automatic program_registers(logic [7:0] last_id, logic [7:0] max_wrong);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_LAST_ID, {24'd0, last_id}, rd);
    apb_access(1'b1, ADDR_MAX_WRONG, {24'd0, max_wrong}, rd);
    model_last_id   = last_id;
    model_max_wrong = max_wrong;
    check_registers();
  endtask

  // --------------------------------------------------------------------------
  // event driver: called just after a falling edge, returns just after one
  // valid is left high on return so back-to-back events never drop it
  // --------------------------------------------------------------------------
  task automatic drive_event(in_item_t ev, bit typed, out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      events_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    events_ch.valid   <= 1'b1;
    events_ch.payload <= ev;
    @(posedge clk_i);
    while (!events_ch.ready) @(posedge clk_i);
    // transfer done at this edge: the model moves on at once
    predicted = relay_step(ev);
    pending_orders.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // sender pauses until the block has answered every event
  task automatic wait_for_orders();
    events_ch.valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [7:0] last_id, logic [7:0] max_wrong,
                           int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned hold);
    program_registers(last_id, max_wrong);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_cycles    = hold;
    repeat (PHASE_ITEMS) drive_event(next_event(), 1'b0, '0);
    wait_for_orders();
  endtask

  // --------------------------------------------------------------------------
  // clock, watchdog, order receiver and monitor
  // --------------------------------------------------------------------------
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ready toggles at random; a long hold-off keeps it low so the block fills up
  initial begin
    orders_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        orders_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        orders_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every order transfer is checked against the oldest outstanding one
  always @(posedge clk_i) begin
    if (rst_ni && orders_ch.valid && orders_ch.ready) check_order(orders_ch.payload);
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    events_ch.valid   = 1'b0;
    events_ch.payload = '0;

    // model at reset: store all ones, registers at their defaults
    model_phase = PH_WAIT_TRK;
    foreach (model_store[i]) model_store[i] = '1;
    model_sent      = 0;
    model_wrong     = '0;
    model_last_id   = LAST_ID_RST;
    model_max_wrong = MAX_WRONG_RST;

    // directed pass with the default registers: stray events in each phase,
    // field extremes, an id past the store, one full sending run, a wrong
    // sender, then base 2 closing the sequence
    add_row(radio_event(CMD_TMO, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_TRK));
    add_row(radio_event(CMD_UNUSED, 8'hff, 8'hff, 16'shffff, 8'shff, 32'hffff_ffff), 1, 1'b1,
            relay_result(ACT_NONE, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_TRK));
    add_row(radio_event(CMD_TXD, 8'd9, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_NONE, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_TRK));
    // base station frame is not a tracker
    add_row(radio_event(CMD_RX, BASE2_ID, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_TRK));
    // lowest tracker id opens the sequence with the minimum values
    add_row(radio_event(CMD_RX, TRACKER_MIN_ID, 8'd0, 16'sh8000, 8'sh80, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_SEQ, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_TRK));
    add_row(radio_event(CMD_RX, 8'hff, 8'd1, 16'sh7fff, 8'sh7f, 32'hffff_ffff), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_SEQ, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_TRK));
    // non-tracker carrying the last id does not close the sequence
    add_row(radio_event(CMD_RX, BASE2_ID, LAST_ID_RST, 16'sd5, 8'sd5, 32'd5), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_SEQ, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_TRK));
    // id past the store: nothing recorded
    add_row(radio_event(CMD_RX, 8'd200, 8'hff, 16'sd7, 8'sd7, 32'd7), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_SEQ, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_TRK));
    add_row(radio_event(CMD_TXD, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_NONE, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_TRK));
    // timeout starts sending with record 0
    add_row(radio_event(CMD_TMO, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_SEND, KIND_TRACKER, 8'd0, 32'd0, 16'sh8000, 8'sh80, PH_TX));
    // timeout has no meaning while sending
    add_row(radio_event(CMD_TMO, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_NONE, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_TX));
    add_row(radio_event(CMD_TXD, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_SEND, KIND_TRACKER, 8'd1, 32'hffff_ffff, 16'sh7fff, 8'sh7f,
                         PH_TX));
    // remaining records, untouched since the clear
    add_row(radio_event(CMD_TXD, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), RECORDS - 2, 1'b0, '0);
    // store exhausted: listen for base 2
    add_row(radio_event(CMD_TXD, 8'd0, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_BASE, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_B2));
    add_row(radio_event(CMD_RX, 8'd5, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_BASE, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_B2));
    add_row(radio_event(CMD_RX, BASE2_ID, 8'd0, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_SEQ, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_B2));
    add_row(radio_event(CMD_RX, 8'd7, LAST_ID_RST, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_SEQ, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_RECV_B2));
    add_row(radio_event(CMD_RX, BASE2_ID, LAST_ID_RST, 16'sd0, 8'sd0, 32'd0), 1, 1'b1,
            relay_result(ACT_LISTEN, KIND_TRACKER, 8'd0, 32'd0, 16'sd0, 8'sd0, PH_WAIT_TRK));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers must come out of reset at their defaults
    check_registers();

    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        drive_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    wait_for_orders();

    // random phases: register extremes, then the idling mixes, then a long
    // receiver hold-off while the sender keeps offering events
    run_phase(8'd0, 8'd1, 0, 0, 0);
    run_phase(8'd255, 8'd255, 75, 0, 0);
    run_phase(LAST_ID_RST, MAX_WRONG_RST, 0, 75, 0);
    run_phase(8'($urandom_range(20)), 8'($urandom_range(6, 1)), 21, 21, 0);
    run_phase(8'd7, 8'd2, 0, 0, LONG_HOLD);

    // nothing more may come out once everything has been answered
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### timestamp_relay_base_sequencer.f
src/tsr_pkg.sv
src/tsr_if.sv
src/tsr_store.sv
src/tsr_ctrl.sv
src/timestamp_relay_base_sequencer.sv
sim/tb_timestamp_relay_base_sequencer.sv
